/* rtl/hpack_prefix_integer_decoder_defines.svh */
// Assertion macros used by the prefix integer decoder RTL.
`ifndef HPACK_PREFIX_INTEGER_DECODER_DEFINES_SVH
`define HPACK_PREFIX_INTEGER_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HPID_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HPID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hpid_pkg.sv */
// Types and constants shared by the prefix integer decoder modules.
`default_nettype none
package hpid_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Byte layout constants
    localparam logic [7:0] GROUP_MASK = 8'd127;
    localparam logic [3:0] MAX_PREFIX = 4'd8;
    localparam logic [3:0] MAX_COUNT  = 4'd15;

    // Classified byte passed from the front end to the accumulator
    typedef struct packed {
        logic       first;  // starts a new integer
        logic [7:0] group;  // prefix bits or 7-bit continuation group
        logic       fin;    // integer completes with this byte
        logic       trunc;  // buffer ends mid-integer on this byte
    } cmd_t;

endpackage
`default_nettype wire

/* rtl/hpid_front.sv */
// Front end: accepts bytes, drops stray continuation bytes, classifies the rest.
`default_nettype none
module hpid_front
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [7:0]         data_byte,
    input  wire                int_start,
    input  wire  [3:0]         prefix_bits,
    input  wire                end_of_buffer,
    output logic               push,
    output hpid_pkg::cmd_t     cmd,
    input  wire                q_ready
);
    import hpid_pkg::*;

    logic       in_progress_reg;
    logic       in_progress_next;
    logic [3:0] n_clamped;
    logic [7:0] limit;
    logic [7:0] prefix;
    logic       accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    // Prefix width clamped to 1..8 and the all-ones limit it implies
    always_comb
    begin
        if (prefix_bits == 4'd0)
            n_clamped = 4'd1;
        else if (prefix_bits > MAX_PREFIX)
            n_clamped = MAX_PREFIX;
        else
            n_clamped = prefix_bits;
        limit  = 8'((9'd1 << n_clamped) - 9'd1);
        prefix = data_byte & limit;
    end

    // Classification of the accepted byte
    always_comb
    begin
        cmd              = '0;
        push             = 1'b0;
        in_progress_next = in_progress_reg;
        cmd.first        = int_start;
        if (int_start)
        begin
            cmd.group = prefix;
            cmd.fin   = (prefix != limit);
            cmd.trunc = (prefix == limit) && end_of_buffer;
        end
        else
        begin
            cmd.group = data_byte & GROUP_MASK;
            cmd.fin   = !data_byte[7];
            cmd.trunc = data_byte[7] && end_of_buffer;
        end
        if (accept && (int_start || in_progress_reg))
        begin
            push             = 1'b1;
            in_progress_next = !cmd.fin && !cmd.trunc;
        end
    end

    // Integer-in-flight flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_progress_reg <= 1'b0;
        else
            in_progress_reg <= in_progress_next;
    end

endmodule
`default_nettype wire

/* rtl/hpid_queue.sv */
// Two-entry queue of classified bytes between front end and accumulator.
`default_nettype none
module hpid_queue
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  hpid_pkg::cmd_t     push_cmd,
    output logic               q_ready,
    output logic               q_valid,
    output hpid_pkg::cmd_t     q_cmd,
    input  wire                pop
);
    import hpid_pkg::*;

    cmd_t       entry_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

/* rtl/hpid_back.sv */
// Back end: saturating shift-add accumulator and result register.
`default_nettype none
`include "hpack_prefix_integer_decoder_defines.svh"
module hpid_back
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                q_valid,
    input  hpid_pkg::cmd_t     q_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [31:0]        value,
    output logic [3:0]         bytes_used,
    output logic [1:0]         status
);
    import hpid_pkg::*;

    localparam int          EFF_W = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam logic [31:0] CAP   = 32'((64'd1 << EFF_W) - 64'd1);

    logic [31:0] acc_reg,   acc_next;
    logic [5:0]  shift_reg, shift_next;
    logic [3:0]  count_reg, count_next;
    logic        ovf_reg,   ovf_next;
    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic [3:0]  bytes_reg;
    logic [1:0]  status_reg;

    logic [31:0] base_acc;
    logic [5:0]  base_shift;
    logic        base_ovf;
    logic [39:0] sum;
    logic [6:0]  shift_inc;
    logic        emit;

    assign pop        = q_valid && (!out_valid_reg || out_ready);
    assign emit       = q_cmd.fin || q_cmd.trunc;
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign bytes_used = bytes_reg;
    assign status     = status_reg;

    // Shift-add with saturation at the value cap
    always_comb
    begin
        base_acc   = q_cmd.first ? 32'd0 : acc_reg;
        base_shift = q_cmd.first ? 6'd0  : shift_reg;
        base_ovf   = q_cmd.first ? 1'b0  : ovf_reg;
        sum        = {8'd0, base_acc} + ({32'd0, q_cmd.group} << base_shift[4:0]);
        shift_inc  = {1'b0, shift_reg} + 7'd7;

        acc_next = base_acc;
        ovf_next = base_ovf;
        if (q_cmd.group != 8'd0)
        begin
            if (base_ovf || base_shift[5])
            begin
                acc_next = CAP;
                ovf_next = 1'b1;
            end
            else if (sum > {8'd0, CAP})
            begin
                acc_next = CAP;
                ovf_next = 1'b1;
            end
            else
            begin
                acc_next = sum[31:0];
            end
        end

        if (q_cmd.first)
        begin
            shift_next = 6'd0;
            count_next = 4'd1;
        end
        else
        begin
            shift_next = (shift_inc > 7'd63) ? 6'd63 : shift_inc[5:0];
            count_next = (count_reg == MAX_COUNT) ? MAX_COUNT : count_reg + 4'd1;
        end
    end

    // Accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 32'd0;
            shift_reg <= 6'd0;
            count_reg <= 4'd0;
            ovf_reg   <= 1'b0;
        end
        else if (pop)
        begin
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            value_reg <= acc_next;
            bytes_reg <= count_next;
            if (q_cmd.trunc)
                status_reg <= ST_TRUNC;
            else if (ovf_next)
                status_reg <= ST_OVF;
            else
                status_reg <= ST_OK;
        end
    end

    // Checks
    `HPID_ASSERT_IMPLY(a_ovf_holds_cap, clk, rst_n, ovf_reg, acc_reg == CAP, "overflow without cap")
    `HPID_ASSERT_IMPLY(a_pop_needs_entry, clk, rst_n, pop, q_valid, "pop from empty queue")
    `HPID_ASSERT_IMPLY(a_result_nonzero_count, clk, rst_n, out_valid_reg, bytes_reg != 4'd0,
        "result with zero byte count")
    `HPID_ASSERT_NEXT(a_emit_loads_result, clk, rst_n, pop && emit, out_valid_reg,
        "completed integer not presented")

endmodule
`default_nettype wire

/* rtl/hpack_prefix_integer_decoder.sv */
// Top level of the header-compression prefix integer decoder.
//
// Input stream: one header-block byte per transfer. tdata carries the byte,
// tuser carries the start-of-integer flag (bit 0) and the prefix width N
// (bits 4:1), and tlast marks the last byte available in the buffer.
// Output stream: one result per completed or truncated integer. tdata holds
// the value (bits 31:0) and the bytes used (bits 35:32); tuser holds status
// (0 ok, 1 saturated overflow, 2 truncated).
// tvalid rises once the byte that ends the integer has passed the queue
// slot and then the shift-add into the result register; a stalled receiver
// can hold it in the queue. Throughput: one byte per cycle while results
// are taken, set by the single shift-add step in the accumulator stage.
// Reset clears the accumulator, the in-flight flag, the two-entry queue and
// the output valid flag; tready is high straight after reset.
// When the receiver stalls, the result register holds its transfer, bytes
// still drain into the queue, and tready drops once the queue is full.
`default_nettype none
module hpack_prefix_integer_decoder
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire  [4:0]  s_axis_tuser,   // int_start[0], prefix_bits[4:1]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value[31:0], bytes_used[35:32], zero[39:36]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import hpid_pkg::*;

    logic        push;
    cmd_t        push_cmd;
    logic        q_ready;
    logic        q_valid;
    cmd_t        q_cmd;
    logic        pop;
    logic [31:0] value;
    logic [3:0]  bytes_used;

    hpid_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .data_byte     (s_axis_tdata),
        .int_start     (s_axis_tuser[0]),
        .prefix_bits   (s_axis_tuser[4:1]),
        .end_of_buffer (s_axis_tlast),
        .push          (push),
        .cmd           (push_cmd),
        .q_ready       (q_ready)
    );

    hpid_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    hpid_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .value      (value),
        .bytes_used (bytes_used),
        .status     (m_axis_tuser)
    );

    assign m_axis_tdata = {4'd0, bytes_used, value};

endmodule
`default_nettype wire
